>>> sv/lsd_pkg.sv
// Shared types and constants for the least-loaded server dispatch block.
// No dependencies; every other file refers to this package by scoped names.
package lsd_pkg;

    localparam int MAX_SERVERS = 64;
    localparam int ID_W        = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
    localparam int LOAD_W      = 32;
    localparam int TIME_W      = 20;
    localparam int SRV_W       = 7;
    localparam int CFG_W       = 7;

    localparam logic REQ_CLEAR = 1'b0;
    localparam logic REQ_JOB   = 1'b1;

    // Token that walks the cell chain carrying the best candidate so far
    typedef struct packed {
        logic              vld;
        logic              have;
        logic [LOAD_W-1:0] load;
        logic [ID_W-1:0]   id;
    } t_scan;

    // Load update broadcast to every cell
    typedef struct packed {
        logic              en;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] svc;
    } t_upd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_UPD,
        ST_SCAN,
        ST_OUT
    } t_state;

endpackage

>>> sv/lsd_in_if.sv
// Input channel of the dispatch block: valid/ready handshake plus job fields.
// Depends on lsd_pkg for field widths.
interface lsd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [lsd_pkg::TIME_W-1:0]  service_time;

    modport source (output valid, output req_type, output service_time, input ready);
    modport sink   (input valid, input req_type, input service_time, output ready);
endinterface

>>> sv/lsd_out_if.sv
// Result channel of the dispatch block: valid/ready handshake plus result fields.
// Depends on lsd_pkg for field widths.
interface lsd_out_if;
    logic                        valid;
    logic                        ready;
    logic [lsd_pkg::SRV_W-1:0]   assigned_server;
    logic [lsd_pkg::SRV_W-1:0]   next_server;
    logic                        load_saturated;

    modport source (output valid, output assigned_server, output next_server,
                    output load_saturated, input ready);
    modport sink   (input valid, input assigned_server, input next_server,
                    input load_saturated, output ready);
endinterface

>>> sv/lsd_cell.sv
// One server cell: holds that server's load and one stage of the min-search chain.
// Depends on lsd_pkg for t_scan, t_upd and widths.
module lsd_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [lsd_pkg::ID_W-1:0]   i_cell_id,
    input  logic [lsd_pkg::CNT_W-1:0]  i_active,
    input  logic                       i_clr,
    input  lsd_pkg::t_upd              i_upd,
    input  lsd_pkg::t_scan             i_scan,
    output lsd_pkg::t_scan             o_scan,
    output logic                       o_sat
);

    logic [lsd_pkg::LOAD_W-1:0] r_load;
    logic [lsd_pkg::LOAD_W-1:0] n_load;
    logic [lsd_pkg::LOAD_W:0]   sum;
    logic                       hit;
    logic                       part;
    lsd_pkg::t_scan             r_scan;
    lsd_pkg::t_scan             n_scan;

    always_comb begin
        sum  = {1'b0, r_load} + (lsd_pkg::LOAD_W + 1)'(i_upd.svc);
        hit  = i_upd.en && (i_upd.id == i_cell_id);
        // saturate on carry out
        n_load = sum[lsd_pkg::LOAD_W] ? {lsd_pkg::LOAD_W{1'b1}}
                                      : sum[lsd_pkg::LOAD_W-1:0];
        o_sat = hit && (&n_load);
        part  = lsd_pkg::CNT_W'(i_cell_id) < i_active;

        n_scan = i_scan;
        // strict compare keeps the lower id on equal loads
        if (i_scan.vld && part && (!i_scan.have || (r_load < i_scan.load))) begin
            n_scan.have = 1'b1;
            n_scan.load = r_load;
            n_scan.id   = i_cell_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= '0;
            r_scan <= '0;
        end else begin
            if (i_clr) begin
                r_load <= '0;
            end else if (hit) begin
                r_load <= n_load;
            end
            r_scan <= n_scan;
        end
    end

    assign o_scan = r_scan;

endmodule

>>> sv/least_loaded_server_dispatch_core.sv
// Top level of the least-loaded server dispatch block: control sequencer and cell chain.
// Depends on lsd_pkg, lsd_in_if, lsd_out_if and lsd_cell.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+------------------------------------------
//  i_job     | in  | valid/ready        | req_type, service_time
//  o_res     | out | valid/ready        | assigned_server, next_server, load_saturated
//  cfg       | in  | i_cfg_we, no wait  | i_cfg_wdata = active_servers
//
// One item at a time. A clear's result is registered and offered in the cycle after it is
// accepted. A job first applies the update, then a token walks the chain of MAX_SERVERS
// cells, one cell per cycle, to find the next least-loaded server. The first job after a
// register write walks the chain once more first.
// Reset is synchronous; all loads are zero and active_servers is 1 after it.
// A stalled result holds the block; no item is taken until it is delivered.
module least_loaded_server_dispatch_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    lsd_in_if.sink                     i_job,
    lsd_out_if.source                  o_res,
    input  logic                       i_cfg_we,
    input  logic [lsd_pkg::CFG_W-1:0]  i_cfg_wdata
);

    localparam int N = lsd_pkg::MAX_SERVERS;

    lsd_pkg::t_state               r_state;
    lsd_pkg::t_state               n_state;
    logic [lsd_pkg::CFG_W-1:0]     r_active;
    logic [lsd_pkg::CNT_W-1:0]     act_cnt;
    logic [lsd_pkg::ID_W-1:0]      r_best_id;
    logic [lsd_pkg::ID_W-1:0]      n_best_id;
    logic                          r_best_ok;
    logic                          n_best_ok;
    logic [lsd_pkg::TIME_W-1:0]    r_time;
    logic                          r_start;
    logic                          n_start;
    logic [lsd_pkg::SRV_W-1:0]     r_assigned;
    logic [lsd_pkg::SRV_W-1:0]     n_assigned;
    logic [lsd_pkg::SRV_W-1:0]     r_next;
    logic [lsd_pkg::SRV_W-1:0]     n_next;
    logic                          r_sat;
    logic                          n_sat;
    logic                          accept;
    logic                          clr;
    lsd_pkg::t_upd                 upd;
    lsd_pkg::t_scan                scan_head;
    lsd_pkg::t_scan                chain [N+1];
    logic [N-1:0]                  sat_vec;

    // Out-of-range register values act as the nearest legal count
    always_comb begin
        if (int'(r_active) == 0) begin
            act_cnt = lsd_pkg::CNT_W'(1);
        end else if (int'(r_active) > N) begin
            act_cnt = lsd_pkg::CNT_W'(N);
        end else begin
            act_cnt = lsd_pkg::CNT_W'(r_active);
        end
    end

    assign accept = i_job.valid && i_job.ready;

    always_comb begin
        scan_head      = '0;
        scan_head.vld  = r_start;
    end

    assign chain[0] = scan_head;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            lsd_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cell_id (lsd_pkg::ID_W'(g)),
                .i_active  (act_cnt),
                .i_clr     (clr),
                .i_upd     (upd),
                .i_scan    (chain[g]),
                .o_scan    (chain[g+1]),
                .o_sat     (sat_vec[g])
            );
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        n_best_id  = r_best_id;
        n_best_ok  = r_best_ok;
        n_start    = 1'b0;
        n_assigned = r_assigned;
        n_next     = r_next;
        n_sat      = r_sat;
        clr        = 1'b0;
        upd        = '0;
        i_job.ready = (r_state == lsd_pkg::ST_IDLE);
        o_res.valid = (r_state == lsd_pkg::ST_OUT);

        case (r_state)
            lsd_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_job.req_type == lsd_pkg::REQ_CLEAR) begin
                        clr        = 1'b1;
                        n_best_id  = '0;
                        n_best_ok  = 1'b1;
                        n_assigned = '0;
                        n_next     = lsd_pkg::SRV_W'(1);
                        n_sat      = 1'b0;
                        n_state    = lsd_pkg::ST_OUT;
                    end else if (r_best_ok) begin
                        upd.en     = 1'b1;
                        upd.id     = r_best_id;
                        upd.svc    = i_job.service_time;
                        n_assigned = lsd_pkg::SRV_W'(r_best_id) + lsd_pkg::SRV_W'(1);
                        n_sat      = |sat_vec;
                        n_start    = 1'b1;
                        n_state    = lsd_pkg::ST_SCAN;
                    end else begin
                        // best server unknown since the last register write
                        n_start = 1'b1;
                        n_state = lsd_pkg::ST_PRE;
                    end
                end
            end
            lsd_pkg::ST_PRE: begin
                if (chain[N].vld) begin
                    n_best_id = chain[N].id;
                    n_best_ok = 1'b1;
                    n_state   = lsd_pkg::ST_UPD;
                end
            end
            lsd_pkg::ST_UPD: begin
                upd.en     = 1'b1;
                upd.id     = r_best_id;
                upd.svc    = r_time;
                n_assigned = lsd_pkg::SRV_W'(r_best_id) + lsd_pkg::SRV_W'(1);
                n_sat      = |sat_vec;
                n_start    = 1'b1;
                n_state    = lsd_pkg::ST_SCAN;
            end
            lsd_pkg::ST_SCAN: begin
                if (chain[N].vld) begin
                    n_best_id = chain[N].id;
                    n_best_ok = 1'b1;
                    n_next    = lsd_pkg::SRV_W'(chain[N].id) + lsd_pkg::SRV_W'(1);
                    n_state   = lsd_pkg::ST_OUT;
                end
            end
            lsd_pkg::ST_OUT: begin
                if (o_res.ready) begin
                    n_state = lsd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lsd_pkg::ST_IDLE;
            end
        endcase

        // a new active count invalidates the stored best server
        if (i_cfg_we) begin
            n_best_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lsd_pkg::ST_IDLE;
            r_active  <= lsd_pkg::CFG_W'(1);
            r_best_id <= '0;
            r_best_ok <= 1'b1;
            r_start   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_best_id <= n_best_id;
            r_best_ok <= n_best_ok;
            r_start   <= n_start;
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_time <= i_job.service_time;
        end
        r_assigned <= n_assigned;
        r_next     <= n_next;
        r_sat      <= n_sat;
    end

    assign o_res.assigned_server = r_assigned;
    assign o_res.next_server     = r_next;
    assign o_res.load_saturated  = r_sat;

endmodule
